### design/pbkdf2_pkg.sv
// Shared types, constants and SHA-256 tables for the PBKDF2-HMAC-SHA256 unit.
// Used by the controller, the datapath and the top level.
package pbkdf2_pkg;

  localparam int MAX_PASSWORD_BYTES = 64;
  localparam int MAX_SALT_BYTES     = 16;
  localparam int PW_AW              = $clog2(MAX_PASSWORD_BYTES);
  localparam int SALT_AW            = $clog2(MAX_SALT_BYTES);
  localparam int ITER_W             = 20;
  localparam logic [ITER_W-1:0] ITER_RESET = 20'd10000;

  localparam logic [1:0] OP_PASSWORD = 2'd0;
  localparam logic [1:0] OP_SALT     = 2'd1;
  localparam logic [1:0] OP_DERIVE   = 2'd2;

  typedef enum logic [2:0] {
    KIND_PAD_I   = 3'd0,
    KIND_PAD_O   = 3'd1,
    KIND_SALT_IN = 3'd2,
    KIND_MSG_IN  = 3'd3,
    KIND_MSG_OUT = 3'd4
  } kind_t;

  typedef struct packed {
    logic       wr_pw;
    logic       wr_salt;
    logic       clear;
    logic       load;
    logic       init;
    logic       round;
    logic       finish;
    logic       first;
    kind_t      kind;
    logic [5:0] idx;
    logic [1:0] word;
  } cmd_t;

  localparam logic [0:7][31:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

### design/pbkdf2_hmac_sha256_derive_unit.sv
// PBKDF2-HMAC-SHA256 single-block key derivation unit, top level.
// Depends on pbkdf2_pkg, pbkdf2_ctrl, pbkdf2_dp, pbkdf2_ram.
//
// Input channel (in_valid/in_stall, op, data_byte): op 0 loads a password
// byte (up to 64; more are dropped and flagged), op 1 loads a salt byte (up
// to 16; more are ignored), op 2 derives the key, op 3 is ignored.
// Load items do not raise in_stall, so they can follow back to back. A
// derive item runs 2 + 2*N SHA-256 compressions, N the iteration count
// (0 counts as 1); each compression assembles the block through the store
// read port, runs 64 rounds on one shared round unit and adds into the
// hash state.
// Output channel (out_valid/out_stall, key_word, last_word,
// password_overflow): four 64-bit big-endian key words, last_word on the
// fourth. While the receiver stalls the word holds and in_stall stays high.
// After the fourth word is taken both load lengths and the overflow flag
// clear and the next item is accepted.
// cfg_write/cfg_data write the iteration count; reset sets it to 10000
// and clears both load lengths and the overflow flag.
module pbkdf2_hmac_sha256_derive_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [63:0]                   key_word,
  output logic                          last_word,
  output logic                          password_overflow,
  input  logic                          cfg_write,
  input  logic [pbkdf2_pkg::ITER_W-1:0] cfg_data
);
  import pbkdf2_pkg::*;

  cmd_t cmd;

  pbkdf2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last_word (last_word),
    .cmd       (cmd)
  );

  pbkdf2_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .data_byte         (data_byte),
    .key_word          (key_word),
    .password_overflow (password_overflow)
  );

endmodule

### design/pbkdf2_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbkdf2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pbkdf2_ctrl.sv
// Controller: item handshake, iteration register and compression sequencing.
// Depends on pbkdf2_pkg; drives the datapath through cmd_t.
module pbkdf2_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic                          cfg_write,
  input  logic [pbkdf2_pkg::ITER_W-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          last_word,
  output pbkdf2_pkg::cmd_t              cmd
);
  import pbkdf2_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_WAIT  = 6'b000100,
    S_ROUND = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [5:0]        cnt, cnt_next;
  kind_t             kind, kind_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic [ITER_W-1:0] iteration_count;
  logic [ITER_W-1:0] count_eff;
  logic [1:0]        wc, wc_next;
  logic              out_valid_next;
  logic              accept;

  assign count_eff = (iteration_count == '0) ? ITER_W'(1) : iteration_count;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign last_word = (wc == 2'd3);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    kind_next      = kind;
    iter_next      = iter;
    wc_next        = wc;
    out_valid_next = out_valid;
    cmd            = '0;
    cmd.kind       = kind;
    cmd.idx        = cnt;
    cmd.word       = wc;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_PASSWORD: cmd.wr_pw = 1'b1;
            OP_SALT:     cmd.wr_salt = 1'b1;
            OP_DERIVE: begin
              state_next = S_LOAD;
              kind_next  = KIND_PAD_I;
              cnt_next   = '0;
              iter_next  = '0;
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        cmd.init = (cnt == '0);
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        cnt_next   = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cnt_next  = cnt + 6'd1;
        if (cnt == 6'd63) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        cmd.first  = (iter == '0);
        cnt_next   = '0;
        state_next = S_LOAD;
        case (kind)
          KIND_PAD_I:   kind_next = KIND_PAD_O;
          KIND_PAD_O:   kind_next = KIND_SALT_IN;
          KIND_SALT_IN: kind_next = KIND_MSG_OUT;
          KIND_MSG_IN:  kind_next = KIND_MSG_OUT;
          KIND_MSG_OUT: begin
            iter_next = iter + ITER_W'(1);
            if ({1'b0, iter} + 21'd1 >= {1'b0, count_eff}) begin
              state_next     = S_OUT;
              wc_next        = '0;
              out_valid_next = 1'b1;
            end else begin
              kind_next = KIND_MSG_IN;
            end
          end
          default: ;
        endcase
      end
      S_OUT: begin
        if (out_valid && !out_stall) begin
          if (wc == 2'd3) begin
            out_valid_next = 1'b0;
            cmd.clear      = 1'b1;
            state_next     = S_IDLE;
          end else begin
            wc_next = wc + 2'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cnt             <= '0;
      kind            <= KIND_PAD_I;
      iter            <= '0;
      wc              <= '0;
      out_valid       <= 1'b0;
      iteration_count <= ITER_RESET;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      kind      <= kind_next;
      iter      <= iter_next;
      wc        <= wc_next;
      out_valid <= out_valid_next;
      if (cfg_write) begin
        iteration_count <= cfg_data;
      end
    end
  end

endmodule

### design/pbkdf2_dp.sv
// Datapath: password and salt stores, block assembly, SHA-256 round unit,
// HMAC pad states, chain value and accumulated key. Depends on pbkdf2_pkg, pbkdf2_ram.
module pbkdf2_dp (
  input  logic             clk,
  input  logic             rst,
  input  pbkdf2_pkg::cmd_t cmd,
  input  logic [7:0]       data_byte,
  output logic [63:0]      key_word,
  output logic             password_overflow
);
  import pbkdf2_pkg::*;

  logic [PW_AW:0]      pw_len;
  logic [SALT_AW:0]    salt_len;
  logic                ovf;
  logic [7:0]          pw_q, salt_q;
  logic                ld_d;
  logic [5:0]          idx_d;
  logic [7:0]          blk_byte;
  logic [511:0]        w;
  logic [0:7][31:0]    h, v, istate, ostate, hsrc, hf;
  logic [255:0]        msg, acc;
  logic [15:0]         salt_bits;
  logic [6:0]          idx7;
  logic [31:0]         w0, wnew, t1, t2;

  pbkdf2_ram #(.WIDTH(8), .DEPTH(MAX_PASSWORD_BYTES)) u_pw_ram (
    .clk   (clk),
    .we    (cmd.wr_pw && (pw_len < (PW_AW+1)'(MAX_PASSWORD_BYTES))),
    .waddr (pw_len[PW_AW-1:0]),
    .wdata (data_byte),
    .raddr (cmd.idx[PW_AW-1:0]),
    .rdata (pw_q)
  );

  pbkdf2_ram #(.WIDTH(8), .DEPTH(MAX_SALT_BYTES)) u_salt_ram (
    .clk   (clk),
    .we    (cmd.wr_salt && (salt_len < (SALT_AW+1)'(MAX_SALT_BYTES))),
    .waddr (salt_len[SALT_AW-1:0]),
    .wdata (data_byte),
    .raddr (cmd.idx[SALT_AW-1:0]),
    .rdata (salt_q)
  );

  assign idx7      = {1'b0, idx_d};
  assign salt_bits = (16'd68 + 16'(salt_len)) << 3;

  always_comb begin
    blk_byte = 8'h00;
    case (cmd.kind)
      KIND_PAD_I, KIND_PAD_O: begin
        blk_byte = (cmd.kind == KIND_PAD_I) ? 8'h36 : 8'h5c;
        if (idx7 < 7'(pw_len)) begin
          blk_byte = blk_byte ^ pw_q;
        end
      end
      KIND_SALT_IN: begin
        if (idx7 < 7'(salt_len)) begin
          blk_byte = salt_q;
        end else if (idx7 == 7'(salt_len) + 7'd3) begin
          blk_byte = 8'h01;
        end else if (idx7 == 7'(salt_len) + 7'd4) begin
          blk_byte = 8'h80;
        end else if (idx_d == 6'd62) begin
          blk_byte = salt_bits[15:8];
        end else if (idx_d == 6'd63) begin
          blk_byte = salt_bits[7:0];
        end
      end
      KIND_MSG_IN, KIND_MSG_OUT: begin
        if (idx_d < 6'd32) begin
          blk_byte = msg[255 - 8*idx_d[4:0] -: 8];
        end else if (idx_d == 6'd32) begin
          blk_byte = 8'h80;
        end else if (idx_d == 6'd62) begin
          blk_byte = 8'h03;
        end
      end
      default: blk_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd.kind)
      KIND_PAD_I, KIND_PAD_O:    hsrc = INIT_H;
      KIND_SALT_IN, KIND_MSG_IN: hsrc = istate;
      default:                   hsrc = ostate;
    endcase
  end

  assign w0   = w[511:480];
  assign wnew = small_s1(w[63:32]) + w[223:192] + small_s0(w[479:448]) + w0;
  assign t1   = v[7] + big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
              + ROUND_K[cmd.idx] + w0;
  assign t2   = big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hf[i] = h[i] + v[i];
    end
  end

  assign key_word          = acc[255 - 64*cmd.word -: 64];
  assign password_overflow = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      pw_len   <= '0;
      salt_len <= '0;
      ovf      <= 1'b0;
      ld_d     <= 1'b0;
    end else begin
      ld_d <= cmd.load;
      if (cmd.clear) begin
        pw_len   <= '0;
        salt_len <= '0;
        ovf      <= 1'b0;
      end else begin
        if (cmd.wr_pw) begin
          if (pw_len < (PW_AW+1)'(MAX_PASSWORD_BYTES)) begin
            pw_len <= pw_len + (PW_AW+1)'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
        if (cmd.wr_salt && (salt_len < (SALT_AW+1)'(MAX_SALT_BYTES))) begin
          salt_len <= salt_len + (SALT_AW+1)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= cmd.idx;
    if (ld_d) begin
      w <= {w[503:0], blk_byte};
    end else if (cmd.round) begin
      w <= {w[479:0], wnew};
    end
    if (cmd.init) begin
      h <= hsrc;
      v <= hsrc;
    end else if (cmd.round) begin
      v <= {t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
    end
    if (cmd.finish) begin
      h <= hf;
      case (cmd.kind)
        KIND_PAD_I: istate <= hf;
        KIND_PAD_O: ostate <= hf;
        KIND_MSG_OUT: begin
          msg <= hf;
          acc <= cmd.first ? hf : (acc ^ hf);
        end
        default: msg <= hf;
      endcase
    end
  end

endmodule

### tb/sv/pbkdf2_hmac_sha256_derive_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for pbkdf2_hmac_sha256_derive_unit: loads passwords and salts, derives keys,
// and checks every key word against a behavioral PBKDF2-HMAC-SHA256 predictor.
// Depends on pbkdf2_pkg and the RTL of the unit only.
module pbkdf2_hmac_sha256_derive_unit_tb;
  import pbkdf2_pkg::*;

  typedef logic [0:7][31:0] hash_words_t;
  typedef logic [0:63][7:0] block_bytes_t;
  typedef struct {
    logic [63:0] key;
    logic        last;
    logic        ovf;
  } key_word_t;
  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
  } load_item_t;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int MAX_REPORTS = 10;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        op;
  logic [7:0]        data_byte;
  logic              out_valid;
  logic              out_stall;
  logic [63:0]       key_word;
  logic              last_word;
  logic              password_overflow;
  logic              cfg_write;
  logic [ITER_W-1:0] cfg_data;

  logic [7:0]        pw_bytes [MAX_PASSWORD_BYTES];
  int                pw_count;
  logic              pw_dropped;
  logic [7:0]        salt_bytes [MAX_SALT_BYTES];
  int                salt_count;
  logic [ITER_W-1:0] iterations;

  key_word_t key_words_due[$];
  int        mismatches;
  int        words_taken;
  int        items_sent;
  int        cycle_count;
  logic      long_hold_done;

  pbkdf2_hmac_sha256_derive_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .key_word(key_word),
    .last_word(last_word),
    .password_overflow(password_overflow),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic hash_words_t sha_compress(hash_words_t h, block_bytes_t b);
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, ch, maj, t1, t2, x, y;
    for (int t = 0; t < 16; t++) begin
      w[t] = {b[4*t], b[4*t+1], b[4*t+2], b[4*t+3]};
    end
    for (int i = 0; i < 8; i++) begin
      v[i] = h[i];
    end
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        x = w[(t - 15) & 15];
        y = w[(t - 2) & 15];
        s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        s1 = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
        w[t & 15] = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
      end
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + ROUND_K[t] + w[t & 15];
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + maj;
      for (int i = 7; i > 0; i--) begin
        v[i] = v[i-1];
      end
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      h[i] = h[i] + v[i];
    end
    return h;
  endfunction

  function automatic logic [255:0] hash_tail(hash_words_t pre, block_bytes_t msg, int len);
    block_bytes_t blk;
    logic [31:0]  bits;
    blk = '0;
    bits = (64 + len) * 8;
    for (int i = 0; i < len; i++) begin
      blk[i] = msg[i];
    end
    blk[len] = 8'h80;
    blk[60] = bits[31:24];
    blk[61] = bits[23:16];
    blk[62] = bits[15:8];
    blk[63] = bits[7:0];
    return sha_compress(pre, blk);
  endfunction

  function automatic block_bytes_t digest_bytes(logic [255:0] d);
    block_bytes_t blk;
    blk = '0;
    for (int i = 0; i < 32; i++) begin
      blk[i] = d[255 - 8*i -: 8];
    end
    return blk;
  endfunction

  function automatic logic [255:0] hmac_mac(hash_words_t inner, hash_words_t outer,
                                            block_bytes_t msg, int len);
    return hash_tail(outer, digest_bytes(hash_tail(inner, msg, len)), 32);
  endfunction

  function automatic logic [255:0] derive_key();
    block_bytes_t ipad, opad, msg;
    hash_words_t  inner, outer;
    logic [255:0] u, acc;
    int           rounds;
    for (int i = 0; i < 64; i++) begin
      ipad[i] = 8'h36;
      opad[i] = 8'h5c;
    end
    for (int i = 0; i < pw_count; i++) begin
      ipad[i] = ipad[i] ^ pw_bytes[i];
      opad[i] = opad[i] ^ pw_bytes[i];
    end
    inner = sha_compress(INIT_H, ipad);
    outer = sha_compress(INIT_H, opad);
    msg = '0;
    for (int i = 0; i < salt_count; i++) begin
      msg[i] = salt_bytes[i];
    end
    msg[salt_count + 3] = 8'h01;
    u = hmac_mac(inner, outer, msg, salt_count + 4);
    acc = u;
    rounds = (iterations == 0) ? 1 : int'(iterations);
    for (int i = 1; i < rounds; i++) begin
      u = hmac_mac(inner, outer, digest_bytes(u), 32);
      acc = acc ^ u;
    end
    return acc;
  endfunction

  task automatic predict_item(logic [1:0] item_op, logic [7:0] item_data);
    logic [255:0] key;
    key_word_t    w;
    case (item_op)
      OP_PASSWORD: begin
        if (pw_count < MAX_PASSWORD_BYTES) begin
          pw_bytes[pw_count] = item_data;
          pw_count++;
        end else begin
          pw_dropped = 1'b1;
        end
      end
      OP_SALT: begin
        if (salt_count < MAX_SALT_BYTES) begin
          salt_bytes[salt_count] = item_data;
          salt_count++;
        end
      end
      OP_DERIVE: begin
        key = derive_key();
        for (int k = 0; k < 4; k++) begin
          w.key = key[255 - 64*k -: 64];
          w.last = (k == 3);
          w.ovf = pw_dropped;
          key_words_due.push_back(w);
        end
        pw_count = 0;
        salt_count = 0;
        pw_dropped = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [1:0] item_op, logic [7:0] item_data);
    int gap;
    in_valid <= 1'b1;
    op <= item_op;
    data_byte <= item_data;
    do @(posedge clk); while (in_stall);
    predict_item(item_op, item_data);
    items_sent++;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (key_words_due.size() == 0);
    @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_iterations(logic [ITER_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    iterations = value;
    @(posedge clk);
  endtask

  task automatic random_sequence();
    int pw_len, salt_len, r;
    r = $urandom_range(0, 9);
    if (r < 7) pw_len = $urandom_range(0, 12);
    else if (r < 9) pw_len = $urandom_range(56, 64);
    else pw_len = $urandom_range(65, 72);
    salt_len = $urandom_range(0, 20);
    while (pw_len > 0 || salt_len > 0) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_item(2'd3, 8'($urandom));
      end else if (pw_len > 0 && (salt_len == 0 || r < 14)) begin
        send_item(OP_PASSWORD, 8'($urandom));
        pw_len--;
      end else begin
        send_item(OP_SALT, 8'($urandom));
        salt_len--;
      end
    end
    send_item(OP_DERIVE, 8'($urandom));
  endtask

  load_item_t directed_items[] = '{
    '{OP_DERIVE, 8'h00},
    '{OP_PASSWORD, 8'h00}, '{OP_PASSWORD, 8'hff}, '{OP_SALT, 8'hff}, '{OP_SALT, 8'h00},
    '{OP_DERIVE, 8'hff},
    '{2'd3, 8'haa}, '{2'd3, 8'h55}, '{OP_SALT, 8'h80}, '{OP_DERIVE, 8'h55},
    '{OP_PASSWORD, 8'h7f}, '{2'd3, 8'hff}, '{OP_DERIVE, 8'h00}
  };
  logic [ITER_W-1:0] phase_counts[] = '{20'd2, 20'd0, 20'd3, 20'd7, 20'd1, 20'd4};

  initial begin
    int seq_count, phase;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_PASSWORD;
    data_byte = 8'h00;
    cfg_write = 1'b0;
    cfg_data = '0;
    pw_count = 0;
    salt_count = 0;
    pw_dropped = 1'b0;
    iterations = ITER_RESET;
    mismatches = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_iterations(20'd1);
    foreach (directed_items[i]) begin
      send_item(directed_items[i].op, directed_items[i].data);
    end
    drain_outputs();
    write_iterations(20'hfffff);
    write_iterations(20'd0);
    foreach (directed_items[i]) begin
      if (i < 6) send_item(directed_items[i].op, directed_items[i].data);
    end
    drain_outputs();
    seq_count = 0;
    phase = 0;
    while (items_sent < 250) begin
      if (seq_count % 4 == 0) begin
        drain_outputs();
        write_iterations(phase_counts[phase % phase_counts.size()]);
        phase++;
      end
      random_sequence();
      seq_count++;
    end
    drain_outputs();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int len;
    out_stall = 1'b0;
    long_hold_done = 1'b0;
    @(negedge rst);
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!long_hold_done && words_taken >= 8) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        len = gap_length();
        if (len > 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    key_word_t due;
    if (!rst && out_valid && !out_stall) begin
      words_taken++;
      if (key_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected key word %h", key_word);
        end
      end else begin
        due = key_words_due.pop_front();
        if (key_word !== due.key || last_word !== due.last
            || password_overflow !== due.ovf) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("key word mismatch: expected %h last %b ovf %b, got %h last %b ovf %b",
                     due.key, due.last, due.ovf, key_word, last_word, password_overflow);
          end
        end
      end
    end
  end

  initial begin
    words_taken = 0;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

### filelist.f
design/pbkdf2_pkg.sv
design/pbkdf2_ram.sv
design/pbkdf2_ctrl.sv
design/pbkdf2_dp.sv
design/pbkdf2_hmac_sha256_derive_unit.sv
tb/sv/pbkdf2_hmac_sha256_derive_unit_tb.sv
